FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition and consequence in the same cycle
`define KCL_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// consequence in the cycle after the condition
`define KCL_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hdl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// types, constants and helpers shared by the keypad code lock
// ----------------------------------------------------------------------------
package kcl_pkg;

   // code store geometry
   localparam int MAX_CODE = 128;
   localparam int POS_W    = $clog2(MAX_CODE);
   localparam int ADDR_W   = POS_W + 1;
   localparam int CS_DEPTH = 2 ** ADDR_W;

   localparam logic [3:0]  END_MARK       = 4'hF;
   localparam logic [15:0] IDLE_TICKS_RST = 16'd10;

   // request op codes
   localparam logic [1:0] OP_FRAME    = 2'd0;
   localparam logic [1:0] OP_PRESENCE = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;

   // special keys
   localparam logic [3:0] KEY_R    = 4'd3;
   localparam logic [3:0] KEY_O    = 4'd7;
   localparam logic [3:0] KEY_HASH = 4'd14;

   // verdict codes
   localparam logic [1:0] VERDICT_NONE    = 2'd0;
   localparam logic [1:0] VERDICT_OPEN    = 2'd1;
   localparam logic [1:0] VERDICT_REJECT  = 2'd2;
   localparam logic [1:0] VERDICT_CHANGED = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] scan_frame;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic       key_valid;
      logic [3:0] key_index;
      logic [6:0] entry_count;
      logic       changing;
      logic       idle_expired;
   } rsp_type;

   typedef enum logic [1:0] {
      EV_NONE,
      EV_KEY,
      EV_PRESENCE,
      EV_TICK
   } ev_kind_type;

   // classified request handed from front to back
   typedef struct packed {
      ev_kind_type kind;
      logic [3:0]  key_index;
   } event_type;

   typedef struct packed {
      logic       is_digit;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type digit_of(logic [3:0] key);
      digit_type d;
      d.is_digit = 1'b1;
      unique case (key)
         4'd0:    d.value = 4'd1;
         4'd1:    d.value = 4'd2;
         4'd2:    d.value = 4'd3;
         4'd4:    d.value = 4'd4;
         4'd5:    d.value = 4'd5;
         4'd6:    d.value = 4'd6;
         4'd8:    d.value = 4'd7;
         4'd9:    d.value = 4'd8;
         4'd10:   d.value = 4'd9;
         4'd13:   d.value = 4'd0;
         default: begin
            d.is_digit = 1'b0;
            d.value    = 4'd0;
         end
      endcase
      return d;
   endfunction

endpackage

FILE: hdl/kcl_ram.sv
// ----------------------------------------------------------------------------
// kcl_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module kcl_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/kcl_front.sv
// ----------------------------------------------------------------------------
// kcl_front
// accepts requests, decodes scan frames and classifies them into events
// ----------------------------------------------------------------------------
module kcl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  kcl_pkg::req_type   req_data,
   input  logic               ev_full,
   output logic               ev_push,
   output kcl_pkg::event_type ev_data
);
   import kcl_pkg::*;

   logic [4:0] last_key_ff, last_key_in;
   logic [4:0] cur_key;

   // last row with any column wins, lowest column within it
   always_comb begin
      cur_key = 5'd0;
      for (int row = 0; row < 4; row++) begin
         for (int col = 3; col >= 0; col--) begin
            if (req_data.scan_frame[row*4 + col]) begin
               cur_key = 5'(row*4 + col + 1);
            end
         end
      end
   end

   always_comb begin
      ev_push           = push && !ev_full;
      last_key_in       = last_key_ff;
      ev_data.kind      = EV_NONE;
      ev_data.key_index = 4'd0;
      unique case (req_data.op)
         OP_FRAME: begin
            if (ev_push) begin
               last_key_in = cur_key;
            end
            if (cur_key != 5'd0 && cur_key != last_key_ff) begin
               ev_data.kind      = EV_KEY;
               ev_data.key_index = 4'(cur_key - 5'd1);
            end
         end
         OP_PRESENCE: ev_data.kind = EV_PRESENCE;
         OP_TICK:     ev_data.kind = EV_TICK;
         default:     ev_data.kind = EV_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_key_ff <= 5'd0;
      end else begin
         last_key_ff <= last_key_in;
      end
   end

endmodule

FILE: hdl/kcl_evq.sv
// ----------------------------------------------------------------------------
// kcl_evq
// two entry event queue between front and back
// ----------------------------------------------------------------------------
module kcl_evq (
   input  logic               clock,
   input  logic               reset,
   input  logic               ev_push,
   input  kcl_pkg::event_type ev_wdata,
   input  logic               ev_pop,
   output logic               ev_full,
   output logic               ev_empty,
   output kcl_pkg::event_type ev_head
);
   import kcl_pkg::*;

   event_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      ev_full   = (count_ff == 2'd2);
      ev_empty  = (count_ff == 2'd0);
      ev_head   = slot_ff[rd_ptr_ff];
      wr_ptr_in = ev_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = ev_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(ev_push) - 2'(ev_pop);
   end

   always_ff @(posedge clock) begin
      if (ev_push) begin
         slot_ff[wr_ptr_ff] <= ev_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/kcl_back.sv
// ----------------------------------------------------------------------------
// kcl_back
// carries out events against the code store and holds the result register
// ----------------------------------------------------------------------------
module kcl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        idle_ticks,
   input  logic               ev_empty,
   input  kcl_pkg::event_type ev_head,
   output logic               ev_pop,
   input  logic               pop,
   output logic               empty,
   output kcl_pkg::rsp_type   rsp_data
);
   import kcl_pkg::*;

   logic              busy_ff, busy_in;
   event_type         cur_ev_ff;
   logic              rd_loaded_ff, rd_loaded_in;
   logic              active_bank_ff, active_bank_in;
   logic [1:0]        bank_loaded_ff, bank_loaded_in;
   logic [POS_W-1:0]  entry_pos_ff, entry_pos_in;
   logic              change_mode_ff, change_mode_in;
   logic [15:0]       idle_count_ff, idle_count_in;
   logic              idle_running_ff, idle_running_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_full_ff, rsp_full_in;

   logic              exec;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [3:0]        ram_wdata, ram_rdata;
   logic [3:0]        stored;
   digit_type         dg;
   logic [1:0]        verdict;
   logic              expired;
   logic [POS_W+6:0]  pos_ext;

   kcl_ram #(
      .WIDTH (4),
      .DEPTH (CS_DEPTH)
   ) u_code_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ev_pop),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      ev_pop    = !busy_ff && !ev_empty;
      exec      = busy_ff && (!rsp_full_ff || pop);
      ram_raddr = {active_bank_ff, entry_pos_ff};
      ram_waddr = {!active_bank_ff, entry_pos_ff};
      ram_we    = 1'b0;
      ram_wdata = END_MARK;

      // a bank never committed holds an empty code
      rd_loaded_in = ev_pop ? bank_loaded_ff[active_bank_ff] : rd_loaded_ff;
      stored       = rd_loaded_ff ? ram_rdata : END_MARK;
      dg           = digit_of(cur_ev_ff.key_index);

      active_bank_in  = active_bank_ff;
      bank_loaded_in  = bank_loaded_ff;
      entry_pos_in    = entry_pos_ff;
      change_mode_in  = change_mode_ff;
      idle_count_in   = idle_count_ff;
      idle_running_in = idle_running_ff;
      verdict         = VERDICT_NONE;
      expired         = 1'b0;

      if (exec) begin
         unique case (cur_ev_ff.kind)
            EV_KEY: begin
               idle_count_in   = idle_ticks;
               idle_running_in = 1'b1;
               priority if (dg.is_digit) begin
                  if (change_mode_ff) begin
                     // keep room for the end mark
                     if (entry_pos_ff < POS_W'(MAX_CODE - 1)) begin
                        ram_we       = 1'b1;
                        ram_wdata    = dg.value;
                        entry_pos_in = entry_pos_ff + POS_W'(1);
                     end
                  end else if (stored == dg.value) begin
                     entry_pos_in = entry_pos_ff + POS_W'(1);
                  end else begin
                     entry_pos_in = '0;
                  end
               end else if (cur_ev_ff.key_index == KEY_HASH) begin
                  if (change_mode_ff) begin
                     ram_we                          = 1'b1;
                     ram_wdata                       = END_MARK;
                     active_bank_in                  = !active_bank_ff;
                     bank_loaded_in[!active_bank_ff] = 1'b1;
                     change_mode_in                  = 1'b0;
                     verdict                         = VERDICT_CHANGED;
                  end else if (stored == END_MARK) begin
                     verdict = VERDICT_OPEN;
                  end else begin
                     verdict = VERDICT_REJECT;
                  end
                  entry_pos_in = '0;
               end else if (cur_ev_ff.key_index == KEY_R) begin
                  change_mode_in = 1'b1;
                  entry_pos_in   = '0;
               end else if (cur_ev_ff.key_index == KEY_O) begin
                  entry_pos_in = '0;
               end else begin
                  // remaining keys only restart the idle timer
               end
            end
            EV_PRESENCE: begin
               idle_count_in   = idle_ticks;
               idle_running_in = 1'b1;
            end
            EV_TICK: begin
               if (idle_running_ff) begin
                  if (idle_count_ff <= 16'd1) begin
                     idle_count_in   = 16'd0;
                     idle_running_in = 1'b0;
                     entry_pos_in    = '0;
                     change_mode_in  = 1'b0;
                     expired         = 1'b1;
                  end else begin
                     idle_count_in = idle_count_ff - 16'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      pos_ext              = {7'd0, entry_pos_in};
      rsp_in               = rsp_ff;
      if (exec) begin
         rsp_in.verdict      = verdict;
         rsp_in.key_valid    = (cur_ev_ff.kind == EV_KEY);
         rsp_in.key_index    = (cur_ev_ff.kind == EV_KEY) ? cur_ev_ff.key_index : 4'd0;
         rsp_in.entry_count  = pos_ext[6:0];
         rsp_in.changing     = change_mode_in;
         rsp_in.idle_expired = expired;
      end

      priority if (exec) begin
         rsp_full_in = 1'b1;
      end else if (pop) begin
         rsp_full_in = 1'b0;
      end else begin
         rsp_full_in = rsp_full_ff;
      end

      priority if (ev_pop) begin
         busy_in = 1'b1;
      end else if (exec) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end

      empty    = !rsp_full_ff;
      rsp_data = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (ev_pop) begin
         cur_ev_ff <= ev_head;
      end
      rd_loaded_ff <= rd_loaded_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         active_bank_ff  <= 1'b0;
         bank_loaded_ff  <= 2'b00;
         entry_pos_ff    <= '0;
         change_mode_ff  <= 1'b0;
         idle_count_ff   <= 16'd0;
         idle_running_ff <= 1'b0;
         rsp_full_ff     <= 1'b0;
      end else begin
         busy_ff         <= busy_in;
         active_bank_ff  <= active_bank_in;
         bank_loaded_ff  <= bank_loaded_in;
         entry_pos_ff    <= entry_pos_in;
         change_mode_ff  <= change_mode_in;
         idle_count_ff   <= idle_count_in;
         idle_running_ff <= idle_running_in;
         rsp_full_ff     <= rsp_full_in;
      end
   end

endmodule

FILE: hdl/keypad_code_lock.sv
// ----------------------------------------------------------------------------
// Keypad code lock: scan frames, presence events and timer ticks go in through
// a queue-like push/full port and each gives exactly one result on the
// empty/pop side, in order. The back end takes one item at a time: it first
// does the registered read of the code store at the current entry position,
// then updates the state and loads the result register once that register
// is free or being popped. A two entry event queue lets requests keep
// arriving while a result waits. There is no clearing pass after reset: a
// bank that has never had a code committed reads as the empty code. The idle
// timeout register is written over the csr port, which is always ready, and
// should only be written while the lock has no request in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keypad_code_lock (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  kcl_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output kcl_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_wdata
);
   import kcl_pkg::*;

   logic [15:0] idle_ticks_ff, idle_ticks_in;
   logic        ev_push, ev_pop, ev_full, ev_empty;
   event_type   ev_wdata, ev_head;

   always_comb begin
      csr_ready     = 1'b1;
      idle_ticks_in = (csr_valid && csr_ready) ? csr_wdata : idle_ticks_ff;
      full          = ev_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ticks_ff <= IDLE_TICKS_RST;
      end else begin
         idle_ticks_ff <= idle_ticks_in;
      end
   end

   kcl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .ev_full  (ev_full),
      .ev_push  (ev_push),
      .ev_data  (ev_wdata)
   );

   kcl_evq u_evq (
      .clock    (clock),
      .reset    (reset),
      .ev_push  (ev_push),
      .ev_wdata (ev_wdata),
      .ev_pop   (ev_pop),
      .ev_full  (ev_full),
      .ev_empty (ev_empty),
      .ev_head  (ev_head)
   );

   kcl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .idle_ticks (idle_ticks_ff),
      .ev_empty   (ev_empty),
      .ev_head    (ev_head),
      .ev_pop     (ev_pop),
      .pop        (pop),
      .empty      (empty),
      .rsp_data   (rsp_data)
   );

   // back end never takes events in consecutive cycles
   `KCL_ASSERT_NEXT(a_pop_spacing, ev_pop, !ev_pop, "event popped twice in a row")
   `KCL_ASSERT_SAME(a_key_idx_zero, !empty && !rsp_data.key_valid, rsp_data.key_index == 4'd0, "key index without key")
   `KCL_ASSERT_SAME(a_expire_clears, !empty && rsp_data.idle_expired, rsp_data.entry_count == 7'd0 && !rsp_data.changing, "expiry left entry state")

endmodule

FILE: bench/kcl_lock_checker.sv
// ----------------------------------------------------------------------------
// kcl_lock_checker
// Watches the request, response and csr channels of the keypad code lock.
// Keeps its own copy of the lock state, predicts the response to every
// accepted request and compares each popped response against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module kcl_lock_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  kcl_pkg::req_type req_data,
   input  logic             empty,
   input  logic             pop,
   input  kcl_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [15:0]      csr_wdata,
   output int               mismatches,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import kcl_pkg::*;

   // digit value per key index, one nibble per key, F for keys that are no digit
   localparam logic [63:0] KEY_DIGITS = 64'hFF0F_F987_F654_F321;
   localparam logic [3:0]  NO_DIGIT   = 4'hF;

   logic [3:0]  code_mem [0:2*MAX_CODE-1];
   logic        active_bank;
   int          entry_pos;
   logic        change_mode;
   logic [4:0]  last_key;
   int          idle_count;
   logic        idle_running;
   logic [15:0] idle_limit;

   rsp_type     awaited_rsp [$];
   int          err_total = 0;
   int          n_checked = 0;

   function automatic void restart_idle();
      idle_count   = int'(idle_limit);
      idle_running = 1'b1;
   endfunction

   function automatic logic [1:0] press_key(logic [3:0] key);
      logic [3:0] digit;
      int         act;
      int         other;
      logic [1:0] verdict;
      digit   = KEY_DIGITS[key*4 +: 4];
      act     = active_bank ? MAX_CODE : 0;
      other   = active_bank ? 0 : MAX_CODE;
      verdict = VERDICT_NONE;
      restart_idle();
      if (digit != NO_DIGIT) begin
         if (change_mode) begin
            // keep one slot free for the end mark
            if (entry_pos < MAX_CODE - 1) begin
               code_mem[other + entry_pos] = digit;
               entry_pos++;
            end
         end else if (entry_pos < MAX_CODE && code_mem[act + entry_pos] == digit) begin
            entry_pos++;
         end else begin
            entry_pos = 0;
         end
      end else if (key == KEY_HASH) begin
         if (change_mode) begin
            if (entry_pos < MAX_CODE)
               code_mem[other + entry_pos] = END_MARK;
            active_bank = ~active_bank;
            change_mode = 1'b0;
            verdict     = VERDICT_CHANGED;
         end else if (entry_pos < MAX_CODE && code_mem[act + entry_pos] == END_MARK) begin
            verdict = VERDICT_OPEN;
         end else begin
            verdict = VERDICT_REJECT;
         end
         entry_pos = 0;
      end else if (key == KEY_R) begin
         change_mode = 1'b1;
         entry_pos   = 0;
      end else if (key == KEY_O) begin
         entry_pos = 0;
      end
      return verdict;
   endfunction

   function automatic rsp_type lock_response(req_type r);
      rsp_type    o;
      logic [4:0] cur;
      logic       found;
      int         row;
      int         col;
      o = '0;
      case (r.op)
         OP_FRAME: begin
            // last active row wins, lowest column within it
            cur = '0;
            for (row = 0; row < 4; row++) begin
               found = 1'b0;
               for (col = 0; col < 4; col++) begin
                  if (!found && r.scan_frame[row*4 + col]) begin
                     cur   = 5'(row*4 + col + 1);
                     found = 1'b1;
                  end
               end
            end
            if (cur != 0 && cur != last_key) begin
               o.key_valid = 1'b1;
               o.key_index = 4'(cur - 5'd1);
               o.verdict   = press_key(o.key_index);
            end
            last_key = cur;
         end
         OP_PRESENCE: restart_idle();
         OP_TICK: begin
            if (idle_running) begin
               if (idle_count <= 1) begin
                  idle_count     = 0;
                  idle_running   = 1'b0;
                  entry_pos      = 0;
                  change_mode    = 1'b0;
                  o.idle_expired = 1'b1;
               end else begin
                  idle_count--;
               end
            end
         end
         default: ;
      endcase
      o.entry_count = entry_pos[6:0];
      o.changing    = change_mode;
      return o;
   endfunction

   task automatic report_mismatch(string msg);
      err_total++;
      if (err_total <= 40)
         $display("%0t ns  mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < 2*MAX_CODE; i++)
            code_mem[i] = END_MARK;
         active_bank  = 1'b0;
         entry_pos    = 0;
         change_mode  = 1'b0;
         last_key     = '0;
         idle_count   = 0;
         idle_running = 1'b0;
         idle_limit   = IDLE_TICKS_RST;
         awaited_rsp.delete();
      end else begin
         if (csr_valid && csr_ready)
            idle_limit = csr_wdata;
         if (pop && !empty) begin
            n_checked++;
            if (awaited_rsp.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with no request waiting",
                                         n_checked));
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.verdict !== want.verdict)
                  report_mismatch($sformatf("response %0d verdict %0d, predicted %0d",
                                            n_checked, rsp_data.verdict, want.verdict));
               if (rsp_data.key_valid !== want.key_valid)
                  report_mismatch($sformatf("response %0d key_valid %0d, predicted %0d",
                                            n_checked, rsp_data.key_valid, want.key_valid));
               if (rsp_data.key_index !== want.key_index)
                  report_mismatch($sformatf("response %0d key_index %0d, predicted %0d",
                                            n_checked, rsp_data.key_index, want.key_index));
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch($sformatf("response %0d entry_count %0d, predicted %0d",
                                            n_checked, rsp_data.entry_count,
                                            want.entry_count));
               if (rsp_data.changing !== want.changing)
                  report_mismatch($sformatf("response %0d changing %0d, predicted %0d",
                                            n_checked, rsp_data.changing, want.changing));
               if (rsp_data.idle_expired !== want.idle_expired)
                  report_mismatch($sformatf("response %0d idle_expired %0d, predicted %0d",
                                            n_checked, rsp_data.idle_expired,
                                            want.idle_expired));
            end
         end
         if (push && !full)
            awaited_rsp.push_back(lock_response(req_data));
      end
      mismatches  <= err_total;
      outstanding <= awaited_rsp.size();
   end

endmodule

FILE: bench/tb_keypad_code_lock.sv
// ----------------------------------------------------------------------------
// tb_keypad_code_lock
// Drives the keypad code lock with key press sequences (code entry, code
// change, clear, abandon on idle timeout) mixed with presence, ticks and
// random frames, under several idle timeout settings and random stalls on
// both sides. The checker beside the lock predicts and compares responses.
// ----------------------------------------------------------------------------
module tb_keypad_code_lock;
   timeunit 1ns;
   timeprecision 1ps;
   import kcl_pkg::*;

   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PHASE_ITEMS = 120;
   // key index per digit, one nibble per digit 0..9
   localparam logic [39:0] DIGIT_KEYS  = 40'hA986_5421_0D;
   localparam logic [3:0]  KEY_A       = 4'd11;
   localparam logic [3:0]  KEY_STAR    = 4'd12;
   localparam logic [3:0]  KEY_B       = 4'd15;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        push      = 1'b0;
   logic        full;
   req_type     req_data  = '0;
   logic        empty;
   logic        pop       = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;

   int          mismatches;
   int          outstanding;
   int          cycles = 0;
   int          sent = 0;
   bit          calm = 1'b0;
   int          held_key = -1;     // -1 when the last decoded key is unknown
   logic [15:0] idle_setting = IDLE_TICKS_RST;
   logic [3:0]  code_digits [$];
   logic [15:0] idle_plan [0:5];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   keypad_code_lock dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   kcl_lock_checker chk (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[keypad_code_lock] ERROR");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off to fill the lock
   initial begin
      int stall_left;
      int taken;
      bit held;
      stall_left = 0;
      taken      = 0;
      held       = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (pop && !empty)
            taken++;
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else if (!held && taken >= 150) begin
            held       = 1'b1;
            pop        <= 1'b0;
            stall_left = 119;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            pop        <= 1'b0;
            stall_left = $urandom_range(0, 5);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   function automatic logic [3:0] key_of(logic [3:0] digit);
      return DIGIT_KEYS[digit*4 +: 4];
   endfunction

   // frame that decodes to key, with stray bits that must not change the decode
   function automatic logic [15:0] frame_of(logic [3:0] key);
      logic [15:0] f;
      logic [15:0] upper;
      int          row;
      int          col;
      row = key / 4;
      col = key % 4;
      f   = 16'h0001 << key;
      if ($urandom_range(0, 1)) begin
         upper = ((16'h000F << (col + 1)) & 16'h000F) << (row*4);
         f = f | (16'($urandom) & ((16'h0001 << (row*4)) - 16'h0001))
               | (16'($urandom) & upper);
      end
      return f;
   endfunction

   task automatic send_req(logic [1:0] op, logic [15:0] frame);
      req_type r;
      r.op         = op;
      r.scan_frame = frame;
      if (!calm && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      sent++;
   endtask

   task automatic press(logic [3:0] key);
      // release first when the same key would otherwise look held
      if (held_key == key || held_key < 0 || $urandom_range(0, 2) == 0)
         send_req(OP_FRAME, 16'h0000);
      send_req(OP_FRAME, frame_of(key));
      if ($urandom_range(0, 4) == 0)
         send_req(OP_FRAME, frame_of(key));
      held_key = int'(key);
   endtask

   task automatic change_code(int len);
      logic [3:0] d;
      int         i;
      press(KEY_R);
      code_digits.delete();
      for (i = 0; i < len; i++) begin
         d = 4'($urandom_range(0, 9));
         press(key_of(d));
         if (code_digits.size() < MAX_CODE - 1)
            code_digits.push_back(d);
      end
      press(KEY_HASH);
   endtask

   // flaw: 0 none, 1 one wrong digit, 2 last digit missing, 3 one digit too many
   task automatic enter_code(int flaw);
      logic [3:0] d;
      int         i;
      int         n;
      int         bad;
      if ($urandom_range(0, 3) != 0)
         press(KEY_O);
      n   = code_digits.size();
      bad = (n > 0) ? $urandom_range(0, n - 1) : 0;
      if (flaw == 2)
         n = n - 1;
      for (i = 0; i < n; i++) begin
         d = code_digits[i];
         if (flaw == 1 && i == bad)
            d = 4'((d + 1 + $urandom_range(0, 8)) % 10);
         press(key_of(d));
      end
      if (flaw == 3)
         press(key_of(4'($urandom_range(0, 9))));
      press(KEY_HASH);
   endtask

   task automatic abandon_change();
      press(KEY_R);
      repeat ($urandom_range(0, 4)) press(key_of(4'($urandom_range(0, 9))));
      repeat (idle_setting + 1) send_req(OP_TICK, 16'($urandom));
   endtask

   task automatic noise();
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 5))
            0:       send_req(OP_UNUSED, 16'($urandom));
            1:       send_req(OP_PRESENCE, 16'($urandom));
            2:       send_req(OP_TICK, 16'($urandom));
            3:       send_req(OP_FRAME, 16'h0001 << $urandom_range(0, 15));
            default: send_req(OP_FRAME, 16'($urandom));
         endcase
      end
      held_key = -1;
   endtask

   task automatic timer_events();
      repeat ($urandom_range(1, 6))
         send_req(($urandom_range(0, 3) == 0) ? OP_PRESENCE : OP_TICK, 16'($urandom));
   endtask

   task automatic random_sequence();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 3)
         change_code($urandom_range(0, 8));
      else if (pick < 9)
         enter_code(0);
      else if (pick < 12)
         enter_code($urandom_range(1, 3));
      else if (pick < 14 && idle_setting <= 16)
         abandon_change();
      else if (pick < 17)
         noise();
      else
         timer_events();
   endtask

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_idle_ticks(logic [15:0] value);
      drain();
      repeat (6) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      idle_setting = value;
   endtask

   initial begin
      int p;
      int goal;
      idle_plan    = '{16'd1, 16'd0, 16'd4, 16'hFFFF, 16'd7, 16'd10};
      idle_plan[4] = 16'($urandom_range(2, 16));
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // lone hash opens with the empty code after reset
      send_req(OP_FRAME, 16'h0001 << KEY_HASH);
      send_req(OP_FRAME, 16'h0000);
      // all keys down: last row, first column
      send_req(OP_FRAME, 16'hFFFF);
      send_req(OP_FRAME, 16'hFFFF);
      send_req(OP_FRAME, 16'h0001 << KEY_A);
      send_req(OP_FRAME, 16'h0001 << KEY_B);
      send_req(OP_UNUSED, 16'hFFFF);
      send_req(OP_PRESENCE, 16'h0000);
      send_req(OP_TICK, 16'h0000);
      // R while already changing restarts the new code
      send_req(OP_FRAME, 16'h0001 << KEY_R);
      send_req(OP_FRAME, 16'h0001 << key_of(4'd0));
      send_req(OP_FRAME, 16'h0001 << KEY_R);
      send_req(OP_FRAME, 16'h0001 << key_of(4'd1));
      send_req(OP_FRAME, 16'h0001 << key_of(4'd0));
      send_req(OP_FRAME, 16'h0001 << KEY_HASH);
      // wrong digit, then clear before hash
      send_req(OP_FRAME, 16'h0001 << key_of(4'd1));
      send_req(OP_FRAME, 16'h0001 << key_of(4'd2));
      send_req(OP_FRAME, 16'h0001 << key_of(4'd1));
      send_req(OP_FRAME, 16'h0001 << key_of(4'd0));
      send_req(OP_FRAME, 16'h0001 << KEY_O);
      send_req(OP_FRAME, 16'h0001 << KEY_HASH);
      send_req(OP_FRAME, 16'h0001 << KEY_STAR);
      code_digits = '{4'd1, 4'd0};
      held_key    = int'(KEY_STAR);

      for (p = 0; p < 6; p++) begin
         set_idle_ticks(idle_plan[p]);
         if (p == 5)
            calm = 1'b1;
         if (p == 3) begin
            // code as long as the store holds, or longer
            change_code($urandom_range(MAX_CODE - 1, MAX_CODE + 3));
            enter_code(0);
         end
         goal = sent + PHASE_ITEMS;
         while (sent < goal)
            random_sequence();
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("[keypad_code_lock] OK");
      else
         $display("[keypad_code_lock] ERROR");
      $finish;
   end

endmodule
